>>> hdl/rci_pkg.sv
// Shared types and constants for the ray / circle intersection pipeline.
// Used by rci_qsin and ray_circle_intersection; depends on nothing.
package rci_pkg;

  // Fixed-point format of the direction vector and the sine polynomial.
  localparam int FRAC_BITS = 30;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Horner steps of the sine polynomial; the unit adds one stage for z^2
  // and one for the final multiply and clamp.
  localparam int HORNER_STEPS = 6;
  localparam int SIN_LAT = HORNER_STEPS + 2;

  // Taylor coefficients of sin(z*pi/2), Q2.30, lowest order first.
  localparam logic [31:0] TAYLOR_Q30 [HORNER_STEPS+1] = '{
    32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
    32'd172272, 32'd3864, 32'd61
  };

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_RADIUS   = 3'd2,
    REG_SOURCE_X = 3'd3,
    REG_SOURCE_Y = 3'd4
  } cfg_reg_t;

  // Quadrant codes taken from the top two angle bits.
  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quad_t;

endpackage

>>> hdl/rci_qsin.sv
// Pipelined quarter-wave sine, sin(z*pi/2) for z in Q1.30, result in Q1.30.
// Depends on rci_pkg for the coefficients and the stage count.
module rci_qsin import rci_pkg::*; (
  input  logic        clk,
  input  logic [30:0] z,
  output logic [30:0] sin_val
);

  logic [30:0] z_s  [HORNER_STEPS+1];
  logic [30:0] z2_s [HORNER_STEPS+1];
  logic [31:0] p_s  [HORNER_STEPS+1];
  logic [61:0] zz;
  logic [62:0] fin;

  // First stage squares the argument.
  assign zz = {31'd0, z} * {31'd0, z};

  always_ff @(posedge clk) begin
    z_s[0]  <= z;
    z2_s[0] <= zz[60:30];
    p_s[0]  <= TAYLOR_Q30[HORNER_STEPS];
  end

  // One Horner step per stage, highest order coefficient first.
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    logic [62:0] prod;
    assign prod = {31'd0, p_s[i]} * {32'd0, z2_s[i]};
    always_ff @(posedge clk) begin
      z_s[i+1]  <= z_s[i];
      z2_s[i+1] <= z2_s[i];
      p_s[i+1]  <= TAYLOR_Q30[HORNER_STEPS-1-i] - prod[61:30];
    end
  end

  // Final multiply by z and clamp to one.
  assign fin = {31'd0, p_s[HORNER_STEPS]} * {32'd0, z_s[HORNER_STEPS]};

  always_ff @(posedge clk) begin
    if (fin[62:30] > {2'd0, ONE_Q30}) begin
      sin_val <= ONE_Q30;
    end else begin
      sin_val <= fin[60:30];
    end
  end

endmodule

>>> hdl/rci_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside. Stand-alone; uses nothing from rci_pkg.
module rci_isqrt #(
  parameter int ROOT_BITS = 27,
  parameter int SIDE_BITS = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  input  logic [2*ROOT_BITS-1:0] radicand,
  input  logic [SIDE_BITS-1:0]   side_in,
  output logic                   valid_out,
  output logic [ROOT_BITS-1:0]   root,
  output logic [SIDE_BITS-1:0]   side_out
);

  localparam int RAD_BITS = 2 * ROOT_BITS;

  logic [RAD_BITS-1:0]  rem_s  [ROOT_BITS+1];
  logic [RAD_BITS-1:0]  rt_s   [ROOT_BITS+1];
  logic [SIDE_BITS-1:0] side_s [ROOT_BITS+1];
  logic                 vld_s  [ROOT_BITS+1];

  assign rem_s[0]  = radicand;
  assign rt_s[0]   = '0;
  assign side_s[0] = side_in;
  assign vld_s[0]  = valid_in;

  // Each stage tries one bit of the root against the running remainder.
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
    localparam logic [RAD_BITS-1:0] BIT_W = RAD_BITS'(1) << (2 * (ROOT_BITS - 1 - i));
    logic [RAD_BITS-1:0] trial;
    assign trial = rt_s[i] + BIT_W;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      side_s[i+1] <= side_s[i];
      if (rem_s[i] >= trial) begin
        rem_s[i+1] <= rem_s[i] - trial;
        rt_s[i+1]  <= (rt_s[i] >> 1) + BIT_W;
      end else begin
        rem_s[i+1] <= rem_s[i];
        rt_s[i+1]  <= rt_s[i] >> 1;
      end
    end
  end

  assign valid_out = vld_s[ROOT_BITS];
  assign root      = rt_s[ROOT_BITS][ROOT_BITS-1:0];
  assign side_out  = side_s[ROOT_BITS];

endmodule

>>> hdl/ray_circle_intersection.sv
// Top level of the ray / circle intersection pipeline.
// Depends on rci_pkg, rci_qsin and rci_isqrt.
//
// One ray angle may be started in every clock cycle; busy stays low, as the
// pipeline never stalls. Each transaction returns one result, marked by done.
// The pipeline depth comes from the Horner stages of the sine unit and from the
// square root unit, which settles one root bit per stage. The receiver cannot
// hold results off, so each result is shown for one cycle only. Write the
// configuration registers only while no transaction is in flight; new values
// apply to rays started after the write.
module ray_circle_intersection import rci_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic [ANGLE_BITS-1:0]        ray_angle,
  output logic                         done,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] hit_x,
  output logic signed [COORD_BITS-1:0] hit_y
);

  // Widths of the geometry datapath.
  localparam int PRE      = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
  localparam int GEO      = COORD_BITS - PRE + 1;
  localparam int RRB      = COORD_BITS - 1 - PRE;
  localparam int BW       = GEO + 3;
  localparam int ROOT     = BW - 1;
  localparam int RAD      = 2 * ROOT;
  localparam int CW       = 2 * GEO + 2;
  localparam int DW       = 2 * BW;
  localparam int TW       = BW + 1;
  localparam int QW       = TW + 3;
  localparam int SUMW     = QW + PRE + 1;
  localparam int FR       = ANGLE_BITS - 2;
  localparam int SIDE     = 2 + BW + 64;
  localparam int PIPE_LAT = SIN_LAT + 9 + ROOT;

  localparam logic [COORD_BITS-2:0] RAD_RESET = (COORD_BITS-1)'(32'd65536);
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  // Configuration registers.
  logic signed [COORD_BITS-1:0] cx, cy, sx, sy;
  logic [COORD_BITS-2:0]        rad;

  // Values derived from the configuration.
  logic signed [COORD_BITS:0] dsx, dsy;
  logic signed [GEO-1:0]      dxg, dyg;
  logic [RRB-1:0]             rrg;
  logic signed [2*GEO-1:0]    sqx, sqy;
  logic [2*RRB-1:0]           sqr;
  logic signed [CW-1:0]       cg;

  // Input stage and angle delay line.
  logic              v_a;
  logic [1:0]        quad_a;
  logic [29:0]       z_a;
  logic [30:0]       sn, cs;
  logic              v_dl [SIN_LAT];
  logic [1:0]        q_dl [SIN_LAT];

  // Geometry stages.
  logic                       v_u, v_m, v_b, v_d1, v_d;
  logic signed [31:0]         ux_u, uy_u, ux_m, uy_m, ux_b, uy_b, ux_d1, uy_d1, ux_d, uy_d;
  logic signed [GEO+31:0]     mx, my;
  logic signed [GEO+32:0]     bsum;
  logic signed [BW-1:0]       b_b, b_d1, b_d;
  logic signed [DW-1:0]       bsq, disc, disc_d;
  logic                       c_neg, c_zero, hit_d, inside_d, outside_d;
  logic [RAD-1:0]             radicand;

  // After the square root.
  logic                       v_s;
  logic [ROOT-1:0]            root;
  logic [SIDE-1:0]            side_in, side_out;
  logic                       hit_s, outside_s;
  logic signed [BW-1:0]       b_s;
  logic signed [31:0]         ux_s, uy_s, ux_t, uy_t;
  logic                       v_t, hit_t, v_p, hit_p;
  logic signed [TW-1:0]       negb, rootx, t_t;
  logic signed [TW+31:0]      px_p, py_p;
  logic signed [TW+32:0]      rx, ry;
  logic signed [SUMW-1:0]     offx, offy, sumx, sumy, satx, saty;

  assign busy = 1'b0;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      rad <= RAD_RESET;
      sx  <= '0;
      sy  <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: cx  <= cfg_data;
        REG_CENTER_Y: cy  <= cfg_data;
        REG_RADIUS:   rad <= cfg_data[COORD_BITS-2:0];
        REG_SOURCE_X: sx  <= cfg_data;
        REG_SOURCE_Y: sy  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Source offset and squared distance follow the registers through dxg, sqx
  // and cg, well before a started ray reaches the stages that use them.
  assign dsx = (COORD_BITS+1)'(sx) - (COORD_BITS+1)'(cx);
  assign dsy = (COORD_BITS+1)'(sy) - (COORD_BITS+1)'(cy);

  always_ff @(posedge clk) begin
    dxg <= dsx[COORD_BITS:PRE];
    dyg <= dsy[COORD_BITS:PRE];
    rrg <= rad[COORD_BITS-2:PRE];
    sqx <= dxg * dxg;
    sqy <= dyg * dyg;
    sqr <= {{RRB{1'b0}}, rrg} * {{RRB{1'b0}}, rrg};
    cg  <= CW'(sqx) + CW'(sqy) - $signed(CW'(sqr));
  end

  // Input register: quadrant and quadrant fraction in Q0.30.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else begin
      v_a <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    quad_a <= ray_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    z_a    <= {ray_angle[FR-1:0], {(32-ANGLE_BITS){1'b0}}};
  end

  rci_qsin u_sin (
    .clk     (clk),
    .z       ({1'b0, z_a}),
    .sin_val (sn)
  );

  rci_qsin u_cos (
    .clk     (clk),
    .z       (ONE_Q30 - {1'b0, z_a}),
    .sin_val (cs)
  );

  // Valid and quadrant wait for the sine units.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIN_LAT; i++) begin
        v_dl[i] <= 1'b0;
      end
    end else begin
      v_dl[0] <= v_a;
      for (int i = 1; i < SIN_LAT; i++) begin
        v_dl[i] <= v_dl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    q_dl[0] <= quad_a;
    for (int i = 1; i < SIN_LAT; i++) begin
      q_dl[i] <= q_dl[i-1];
    end
  end

  // Valid bits of the geometry stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_u  <= 1'b0;
      v_m  <= 1'b0;
      v_b  <= 1'b0;
      v_d1 <= 1'b0;
      v_d  <= 1'b0;
      v_t  <= 1'b0;
      v_p  <= 1'b0;
      done <= 1'b0;
    end else begin
      v_u  <= v_dl[SIN_LAT-1];
      v_m  <= v_u;
      v_b  <= v_m;
      v_d1 <= v_b;
      v_d  <= v_d1;
      v_t  <= v_s;
      v_p  <= v_t;
      done <= v_p;
    end
  end

  // Unit direction from the quadrant.
  always_ff @(posedge clk) begin
    case (quad_t'(q_dl[SIN_LAT-1]))
      QUAD_FIRST: begin
        ux_u <= $signed({1'b0, cs});
        uy_u <= $signed({1'b0, sn});
      end
      QUAD_SECOND: begin
        ux_u <= -$signed({1'b0, sn});
        uy_u <= $signed({1'b0, cs});
      end
      QUAD_THIRD: begin
        ux_u <= -$signed({1'b0, cs});
        uy_u <= -$signed({1'b0, sn});
      end
      QUAD_FOURTH: begin
        ux_u <= $signed({1'b0, sn});
        uy_u <= -$signed({1'b0, cs});
      end
      default: begin
        ux_u <= '0;
        uy_u <= '0;
      end
    endcase
  end

  // Projection of the source offset on the direction, rounded.
  assign bsum = (GEO+33)'(mx) + (GEO+33)'(my) + (GEO+33)'(1 << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    mx    <= dxg * ux_u;
    my    <= dyg * uy_u;
    ux_m  <= ux_u;
    uy_m  <= uy_u;
    b_b   <= bsum[GEO+32:FRAC_BITS];
    ux_b  <= ux_m;
    uy_b  <= uy_m;
    bsq   <= b_b * b_b;
    b_d1  <= b_b;
    ux_d1 <= ux_b;
    uy_d1 <= uy_b;
  end

  // Discriminant and hit decision.
  assign disc   = bsq - DW'(cg);
  assign c_neg  = cg < 0;
  assign c_zero = cg == '0;

  always_ff @(posedge clk) begin
    disc_d    <= disc;
    b_d       <= b_d1;
    ux_d      <= ux_d1;
    uy_d      <= uy_d1;
    inside_d  <= c_neg;
    outside_d <= !c_neg && !c_zero;
    hit_d     <= c_neg || (c_zero && b_d1 < 0) ||
                 (!c_neg && !c_zero && b_d1 < 0 && disc > 0);
  end

  // A hit always has a non-negative discriminant; misses take zero.
  assign radicand = hit_d ? disc_d[RAD-1:0] : '0;
  assign side_in  = {hit_d, outside_d, b_d, ux_d, uy_d};

  rci_isqrt #(
    .ROOT_BITS (ROOT),
    .SIDE_BITS (SIDE)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v_d),
    .radicand  (radicand),
    .side_in   (side_in),
    .valid_out (v_s),
    .root      (root),
    .side_out  (side_out)
  );

  assign {hit_s, outside_s, b_s, ux_s, uy_s} = side_out;

  // Distance along the ray: near crossing from outside, exit from inside.
  assign negb  = -TW'(b_s);
  assign rootx = $signed(TW'(root));

  always_ff @(posedge clk) begin
    t_t   <= outside_s ? negb - rootx : negb + rootx;
    hit_t <= hit_s;
    ux_t  <= ux_s;
    uy_t  <= uy_s;
    px_p  <= t_t * ux_t;
    py_p  <= t_t * uy_t;
    hit_p <= hit_t;
  end

  // Hit point, scaled back and saturated.
  assign rx   = (TW+33)'(px_p) + (TW+33)'(1 << (FRAC_BITS - 1));
  assign ry   = (TW+33)'(py_p) + (TW+33)'(1 << (FRAC_BITS - 1));
  assign offx = SUMW'($signed(rx[TW+32:FRAC_BITS])) <<< PRE;
  assign offy = SUMW'($signed(ry[TW+32:FRAC_BITS])) <<< PRE;
  assign sumx = offx + SUMW'(sx);
  assign sumy = offy + SUMW'(sy);
  assign satx = (sumx > SAT_HI) ? SAT_HI : ((sumx < SAT_LO) ? SAT_LO : sumx);
  assign saty = (sumy > SAT_HI) ? SAT_HI : ((sumy < SAT_LO) ? SAT_LO : sumy);

  always_ff @(posedge clk) begin
    hit   <= hit_p;
    hit_x <= hit_p ? satx[COORD_BITS-1:0] : '0;
    hit_y <= hit_p ? saty[COORD_BITS-1:0] : '0;
  end

  // Every started ray returns a result, marked by done.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("result did not appear at the pipeline latency");

  // A source inside the circle always hits, with a positive discriminant.
  a_inside: assert property (@(posedge clk) disable iff (rst)
    (v_d && inside_d) |-> (hit_d && disc_d > 0))
    else $error("inside source without a hit");

  // From outside, a hit needs the circle ahead and a real crossing.
  a_outside: assert property (@(posedge clk) disable iff (rst)
    (v_d && outside_d && hit_d) |-> (b_d < 0 && disc_d > 0))
    else $error("outside hit without a forward crossing");

endmodule

>>> test/tb_ray_circle_intersection.sv
// Self-checking testbench for ray_circle_intersection: directed rays, then random
// configurations and angles, each checked by a built-in predictor or as a miss.
// Depends on rci_pkg and the ray_circle_intersection RTL.
`timescale 1ns / 1ps

module tb_ray_circle_intersection;
  import rci_pkg::*;

  localparam int CB = 24;
  localparam int AB = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_RAYS = 1700;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CB-1:0] cfg_data;
  logic start;
  logic busy;
  logic [AB-1:0] ray_angle;
  logic done;
  logic hit;
  logic signed [CB-1:0] hit_x;
  logic signed [CB-1:0] hit_y;

  // Fixed expectation that travels with the ray being driven.
  logic cur_fixed;
  logic cur_hit;
  logic [CB-1:0] cur_x;
  logic [CB-1:0] cur_y;

  typedef struct packed {
    logic hit;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } crossing_t;

  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CB-1:0] data;
    logic [AB-1:0] ang;
    bit fixed;
    crossing_t want;
  } stim_row_t;

  crossing_t pending_q[$];
  stim_row_t dir_tbl[$];

  // Local copy of the circle and source registers.
  logic signed [CB-1:0] m_cx, m_cy, m_sx, m_sy;
  logic [CB-2:0] m_rad;

  int n_errors = 0;
  int n_rays = 0;
  int n_hits = 0;
  int n_setups = 0;

  ray_circle_intersection #(.COORD_BITS(CB), .ANGLE_BITS(AB)) u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .ray_angle(ray_angle),
    .done(done), .hit(hit), .hit_x(hit_x), .hit_y(hit_y)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Timeout waiting for the pipeline to finish.");
    $display("*** FAILED ***");
    $finish;
  end

  // Sine of a quarter turn by the truncated Taylor series, Q1.30.
  function automatic longint unsigned quarter_sine(input longint unsigned z);
    longint unsigned z2;
    longint unsigned p;
    z2 = (z * z) >> 30;
    p = 64'(TAYLOR_Q30[6]);
    for (int k = 5; k >= 0; k--) p = 64'(TAYLOR_Q30[k]) - ((p * z2) >> 30);
    p = (p * z) >> 30;
    if (p > 64'(ONE_Q30)) p = 64'(ONE_Q30);
    return p;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    lo = -(longint'(1) <<< (CB - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // First forward crossing of the ray with the current circle.
  function automatic crossing_t cast_ray(input logic [AB-1:0] ang);
    crossing_t res;
    quad_t quad;
    longint unsigned z;
    longint sn, cs, ux, uy, dx, dy, rr, c, b, disc, t, root;
    bit h;
    quad = quad_t'(ang[AB-1:AB-2]);
    z = longint'(ang[AB-3:0]) << (32 - AB);
    sn = quarter_sine(z);
    cs = quarter_sine(64'(ONE_Q30) - z);
    case (quad)
      QUAD_FIRST:  begin ux = cs;  uy = sn;  end
      QUAD_SECOND: begin ux = -sn; uy = cs;  end
      QUAD_THIRD:  begin ux = -cs; uy = -sn; end
      default:     begin ux = sn;  uy = -cs; end
    endcase
    dx = longint'(m_sx) - longint'(m_cx);
    dy = longint'(m_sy) - longint'(m_cy);
    rr = longint'(m_rad);
    c = dx * dx + dy * dy - rr * rr;
    b = (dx * ux + dy * uy + (longint'(1) <<< 29)) >>> 30;
    disc = b * b - c;
    if (c < 0) h = 1'b1;
    else if (c == 0) h = (b < 0);
    else h = (b < 0) && (disc > 0);
    res = '0;
    res.hit = h;
    if (h) begin
      root = longint'(root_floor(disc));
      t = (c > 0) ? (-b - root) : (-b + root);
      res.x = CB'(clamp_coord(longint'(m_sx) + ((t * ux + (longint'(1) <<< 29)) >>> 30)));
      res.y = CB'(clamp_coord(longint'(m_sy) + ((t * uy + (longint'(1) <<< 29)) >>> 30)));
    end
    return res;
  endfunction

  // Record each accepted transaction with its expected crossing.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      if (cur_fixed) pending_q.insert(pending_q.size(), crossing_t'{cur_hit, cur_x, cur_y});
      else pending_q.insert(pending_q.size(), cast_ray(ray_angle));
    end
  end

  // Compare every result with the oldest expectation.
  always @(posedge clk) begin
    crossing_t exp_c;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("Result with no transaction outstanding");
        n_errors++;
      end else begin
        exp_c = pending_q.pop_front();
        if (hit) n_hits++;
        if (hit !== exp_c.hit) begin
          $error("hit: expected %0d, actual %0d", exp_c.hit, hit);
          n_errors++;
        end
        if (hit_x !== exp_c.x) begin
          $error("hit_x: expected %0d, actual %0d", $signed(exp_c.x), hit_x);
          n_errors++;
        end
        if (hit_y !== exp_c.y) begin
          $error("hit_y: expected %0d, actual %0d", $signed(exp_c.y), hit_y);
          n_errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one ray and hold it until the pipeline takes it.
  task automatic send_ray(input logic [AB-1:0] ang, input bit fixed, input crossing_t want,
                          input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    ray_angle <= ang;
    cur_fixed <= fixed;
    cur_hit <= want.hit;
    cur_x <= want.x;
    cur_y <= want.y;
    do @(posedge clk); while (busy);
    n_rays++;
  endtask

  // Let every outstanding transaction complete.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CB-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CENTER_X: m_cx = data;
      REG_CENTER_Y: m_cy = data;
      REG_RADIUS:   m_rad = data[CB-2:0];
      REG_SOURCE_X: m_sx = data;
      REG_SOURCE_Y: m_sy = data;
      default: ;
    endcase
  endtask

  // Append one row to the directed table.
  task automatic add_row(input stim_row_t r);
    dir_tbl.insert(dir_tbl.size(), r);
  endtask

  function automatic stim_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CB-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t ray_row(input logic [AB-1:0] ang, input bit miss);
    stim_row_t r;
    r = '{default: '0};
    r.ang = ang;
    r.fixed = miss;
    return r;
  endfunction

  // Small coordinate near the origin, or now and then anywhere in range.
  function automatic logic [CB-1:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return CB'($urandom);
    return CB'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
  endfunction

  initial begin
    stim_row_t row;
    int gap_mode;
    logic [CB-1:0] v;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    ray_angle = '0;
    cur_fixed = 1'b0;
    cur_hit = 1'b0;
    cur_x = '0;
    cur_y = '0;
    m_cx = '0;
    m_cy = '0;
    m_sx = '0;
    m_sy = '0;
    m_rad = 23'd65536;

    // Reset circle: unit radius around the source.
    add_row(ray_row(16'h0000, 0));
    add_row(ray_row(16'h4000, 0));
    add_row(ray_row(16'h8000, 0));
    add_row(ray_row(16'hC000, 0));
    add_row(ray_row(16'hFFFF, 0));
    add_row(ray_row(16'h2000, 0));
    // A point circle is never hit.
    add_row(reg_row(REG_RADIUS, 24'd0));
    add_row(ray_row(16'h0000, 1));
    add_row(ray_row(16'h1234, 1));
    // Source outside: near crossing ahead, circle behind, glancing hit.
    add_row(reg_row(REG_CENTER_X, 24'h0A0000));
    add_row(reg_row(REG_RADIUS, 24'h020000));
    add_row(ray_row(16'h0000, 0));
    add_row(ray_row(16'h8000, 0));
    add_row(ray_row(16'h0800, 0));
    // Tangent ray along +x.
    add_row(reg_row(REG_CENTER_Y, 24'h020000));
    add_row(ray_row(16'h0000, 0));
    // Source on the circle.
    add_row(reg_row(REG_CENTER_Y, 24'h000000));
    add_row(reg_row(REG_SOURCE_X, 24'h080000));
    add_row(ray_row(16'h0000, 0));
    add_row(ray_row(16'h8000, 0));
    // Far crossing beyond the coordinate range saturates.
    add_row(reg_row(REG_CENTER_X, 24'h7FFFFF));
    add_row(reg_row(REG_RADIUS, 24'h7FFFFF));
    add_row(reg_row(REG_SOURCE_X, 24'h000000));
    add_row(ray_row(16'h0000, 0));
    add_row(ray_row(16'h8000, 0));
    add_row(ray_row(16'hC000, 0));
    // Extreme corners of the coordinate range.
    add_row(reg_row(REG_CENTER_X, 24'h800000));
    add_row(reg_row(REG_CENTER_Y, 24'h800000));
    add_row(reg_row(REG_SOURCE_X, 24'h7FFFFF));
    add_row(reg_row(REG_SOURCE_Y, 24'h7FFFFF));
    add_row(ray_row(16'h8000, 0));
    add_row(ray_row(16'hA000, 0));
    add_row(ray_row(16'h6000, 0));
    // A write to an unused index changes nothing.
    add_row(reg_row(REG_UNUSED, 24'hFFFFFF));
    add_row(ray_row(16'h1000, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.idx, row.data);
      end else begin
        send_ray(row.ang, row.fixed, row.want, pick_gap());
      end
    end

    // Random part: a fresh circle and source every hundred rays or so.
    while (n_rays < RANDOM_RAYS + dir_tbl.size()) begin
      drain();
      n_setups++;
      write_reg(REG_CENTER_X, rand_coord());
      write_reg(REG_CENTER_Y, rand_coord());
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = CB'($urandom_range(0, 23'h7FFFFF));
        default: v = CB'($urandom_range(1, 12 << 16));
      endcase
      write_reg(REG_RADIUS, v);
      if ($urandom_range(0, 2) == 0) begin
        // Source close to the center, often inside the circle.
        write_reg(REG_SOURCE_X, m_cx + CB'(int'($urandom_range(0, 8 << 16)) - (4 << 16)));
        write_reg(REG_SOURCE_Y, m_cy + CB'(int'($urandom_range(0, 8 << 16)) - (4 << 16)));
      end else begin
        write_reg(REG_SOURCE_X, rand_coord());
        write_reg(REG_SOURCE_Y, rand_coord());
      end
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, CB'($urandom));
      gap_mode = $urandom_range(0, 3);
      repeat ($urandom_range(60, 140)) begin
        send_ray(AB'($urandom_range(0, 65535)), 0, '0, (gap_mode == 0) ? 0 : pick_gap());
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d rays over %0d random circle setups; %0d of them hit.",
             n_rays, n_setups, n_hits);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing.", n_errors, pending_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rci_pkg.sv
hdl/rci_qsin.sv
hdl/rci_isqrt.sv
hdl/ray_circle_intersection.sv
test/tb_ray_circle_intersection.sv
